/* design/tds_pkg.sv */
`timescale 1ns / 1ps

package tds_pkg;

	localparam int COORD_BITS     = 12;
	localparam int SCORE_BITS     = 16;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 2;
	localparam int MAX_POINTS_DEF = 64;

	localparam logic [SCORE_BITS-1:0] THRESHOLD_RST = 16'd19661;
	localparam logic [COORD_BITS-1:0] TMPL_W_RST    = 12'd32;
	localparam logic [COORD_BITS-1:0] TMPL_H_RST    = 12'd32;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_TMPL_W    = 2'd1,
		REG_TMPL_H    = 2'd2,
		REG_NONE      = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic signed [SCORE_BITS-1:0] score;
		logic [COORD_BITS-1:0]        col;
		logic [COORD_BITS-1:0]        row;
		logic                         frame_start;
	} item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] point_x;
		logic [COORD_BITS-1:0] point_y;
		logic                  table_overflow;
	} result_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} point_t;

	typedef struct packed {
		logic   valid;
		logic   clear;
		logic   cand;
		point_t pt;
	} req_t;

endpackage

/* design/tds_scan.sv */
`timescale 1ns / 1ps

module tds_scan #(
	parameter int MAX_POINTS = tds_pkg::MAX_POINTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tds_pkg::req_t                   req,
	input  logic [tds_pkg::COORD_BITS-1:0]  tmpl_w,
	input  logic [tds_pkg::COORD_BITS-1:0]  tmpl_h,
	output logic                            busy,
	output logic                            res_valid,
	output tds_pkg::result_t                res
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW    = tds_pkg::COORD_BITS;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	function automatic logic [CW-1:0] absdiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	state_t                 state_q, state_d;
	logic [CNT_W-1:0]       count_q, count_d;
	logic [CNT_W-1:0]       issue_q, issue_d;
	tds_pkg::point_t        cand_q, cand_d;
	logic                   rd_vld_s1, rd_vld_d;
	tds_pkg::point_t        rd_pt_s1;
	tds_pkg::point_t        mem_q [MAX_POINTS];
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_idx;
	tds_pkg::point_t        wr_pt;
	logic                   emit;
	logic                   emit_ovf;
	tds_pkg::point_t        emit_pt;
	tds_pkg::result_t       res_q;
	logic                   res_vld_q;
	logic                   issue_more;
	logic                   full;
	logic                   hit;

	assign issue_more = (issue_q != count_q);
	assign full       = (count_q == CNT_W'(MAX_POINTS));
	assign hit        = rd_vld_s1
		&& (absdiff(rd_pt_s1.x, cand_q.x) < tmpl_w)
		&& (absdiff(rd_pt_s1.y, cand_q.y) < tmpl_h);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		issue_d  = issue_q;
		cand_d   = cand_q;
		rd_vld_d = 1'b0;
		emit     = 1'b0;
		emit_ovf = 1'b0;
		emit_pt  = req.pt;
		wr_en    = 1'b0;
		wr_idx   = '0;
		wr_pt    = req.pt;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					if (req.clear) begin
						count_d = '0;
					end
					if (req.cand) begin
						if (req.clear || (count_q == '0)) begin
							emit    = 1'b1;
							emit_pt = req.pt;
							wr_en   = 1'b1;
							wr_idx  = '0;
							wr_pt   = req.pt;
							count_d = CNT_W'(1);
						end else begin
							cand_d  = req.pt;
							issue_d = '0;
							state_d = ST_SCAN;
						end
					end
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_d = ST_IDLE;
				end else if (!issue_more && !rd_vld_s1) begin
					emit     = 1'b1;
					emit_pt  = cand_q;
					emit_ovf = full;
					state_d  = ST_IDLE;
					if (!full) begin
						wr_en   = 1'b1;
						wr_idx  = count_q[IDX_W-1:0];
						wr_pt   = cand_q;
						count_d = CNT_W'(count_q + 1'b1);
					end
				end else begin
					rd_vld_d = issue_more;
					if (issue_more) begin
						issue_d = CNT_W'(issue_q + 1'b1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			issue_q   <= issue_d;
			rd_vld_s1 <= rd_vld_d;
			res_vld_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		cand_q <= cand_d;
		if (emit) begin
			res_q.point_x        <= emit_pt.x;
			res_q.point_y        <= emit_pt.y;
			res_q.table_overflow <= emit_ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_pt;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_d) begin
			rd_pt_s1 <= mem_q[issue_q[IDX_W-1:0]];
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = res_vld_q;
	assign res       = res_q;

endmodule

/* design/threshold_detection_suppressor_top.sv */
`timescale 1ns / 1ps
// Greedy non-maximum suppression over a raster stream of match scores.
// Input: raise start with an item (score, col, row, frame_start); the item is
// taken at an edge where start is high and busy is low. frame_start empties the
// point table before the item is handled.
// Output: an accepted point shows on result for one cycle with result_valid.
// The receiver cannot stall; every result must be taken in that cycle.
// Config: cfg_valid/cfg_ready with cfg_index (0 threshold, 1 width, 2 height)
// and cfg_data; cfg_ready is always high. Write only while the block is idle.
// Flow: a score below threshold leaves busy low and gives no result.
// A candidate with no stored points is stored and emitted in the next cycle.
// A candidate with n stored points walks the table through one read port and
// one shared distance compare, one point per cycle, with busy high for the walk;
// result in the first cycle with busy low. A suppressed candidate ends its walk
// at the first close point.
// Reset clears the table count, the sequencer and restores the registers to
// threshold 0.6 (Q1.15) and a 32 by 32 template. Table contents need no reset.
module threshold_detection_suppressor_top #(
	parameter int MAX_POINTS = tds_pkg::MAX_POINTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  tds_pkg::item_t                      item,
	output logic                                result_valid,
	output tds_pkg::result_t                    result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tds_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [tds_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	logic signed [tds_pkg::SCORE_BITS-1:0] threshold_q;
	logic [tds_pkg::COORD_BITS-1:0]        tmpl_w_q;
	logic [tds_pkg::COORD_BITS-1:0]        tmpl_h_q;
	tds_pkg::req_t                         req;
	logic                                  cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= tds_pkg::THRESHOLD_RST;
			tmpl_w_q    <= tds_pkg::TMPL_W_RST;
			tmpl_h_q    <= tds_pkg::TMPL_H_RST;
		end else if (cfg_we) begin
			unique case (tds_pkg::reg_index_t'(cfg_index))
				tds_pkg::REG_THRESHOLD: threshold_q <= cfg_data[tds_pkg::SCORE_BITS-1:0];
				tds_pkg::REG_TMPL_W:    tmpl_w_q    <= cfg_data[tds_pkg::COORD_BITS-1:0];
				tds_pkg::REG_TMPL_H:    tmpl_h_q    <= cfg_data[tds_pkg::COORD_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		req.valid = start && !busy;
		req.clear = item.frame_start;
		req.cand  = !(item.score < threshold_q);
		req.pt.x  = item.col;
		req.pt.y  = item.row;
	end

	tds_scan #(
		.MAX_POINTS (MAX_POINTS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.tmpl_w    (tmpl_w_q),
		.tmpl_h    (tmpl_h_q),
		.busy      (busy),
		.res_valid (result_valid),
		.res       (result)
	);

endmodule

/* design/tds_checker.sv */
`timescale 1ns / 1ps

module tds_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic result_valid
);

	// busy only follows an accepted transaction
	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without an accepted transaction");

	a_no_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !result_valid)
		else $error("result shown while busy");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($past(busy) && !busy) || $past(start && !busy))
		else $error("result without a finished transaction");

endmodule

bind threshold_detection_suppressor_top tds_checker u_tds_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid)
);

/* sim/threshold_detection_suppressor_top_tb.sv */
`timescale 1ns / 1ps

module threshold_detection_suppressor_top_tb;

	localparam int CAPACITY = tds_pkg::MAX_POINTS_DEF;
	localparam int LIMIT_NS = 12_000_000;
	localparam int CW       = tds_pkg::COORD_BITS;
	localparam int SW       = tds_pkg::SCORE_BITS;
	localparam int DW       = tds_pkg::CFG_DATA_BITS;

	typedef enum logic [1:0] {
		OUT_MODEL,
		OUT_NONE,
		OUT_POINT
	} outcome_t;

	typedef struct {
		bit                  is_cfg;
		tds_pkg::reg_index_t idx;
		logic [DW-1:0]       data;
		tds_pkg::item_t      it;
		outcome_t            outcome;
		tds_pkg::result_t    res;
	} step_row_t;

	logic                               clk          = 1'b0;
	logic                               arst_n       = 1'b0;
	logic                               start        = 1'b0;
	logic                               busy;
	tds_pkg::item_t                     item         = '0;
	logic                               result_valid;
	tds_pkg::result_t                   result;
	logic                               cfg_valid    = 1'b0;
	logic                               cfg_ready;
	logic [tds_pkg::CFG_INDEX_BITS-1:0] cfg_index    = '0;
	logic [DW-1:0]                      cfg_data     = '0;

	logic [CW-1:0]        tbl_x [CAPACITY];
	logic [CW-1:0]        tbl_y [CAPACITY];
	int                   tbl_n     = 0;
	logic signed [SW-1:0] thr_q     = tds_pkg::THRESHOLD_RST;
	logic [CW-1:0]        width_q   = tds_pkg::TMPL_W_RST;
	logic [CW-1:0]        height_q  = tds_pkg::TMPL_H_RST;
	tds_pkg::result_t     due_points [$];
	tds_pkg::result_t     want;
	int                   err_count = 0;

	threshold_detection_suppressor_top #(
		.MAX_POINTS(CAPACITY)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#(LIMIT_NS);
		$display("threshold_detection_suppressor_top_tb: errors");
		$finish;
	end

	task automatic flag_error(input string msg);
		err_count++;
		$display("%0t ns mismatch: %s", $time, msg);
	endtask

	function automatic bit suppress_step(input tds_pkg::item_t it, output tds_pkg::result_t r);
		int k;
		int dx;
		int dy;
		r = '0;
		if (it.frame_start)
			tbl_n = 0;
		if ($signed(it.score) < $signed(thr_q))
			return 1'b0;
		for (k = 0; k < tbl_n; k++) begin
			dx = int'(tbl_x[k]) - int'(it.col);
			dy = int'(tbl_y[k]) - int'(it.row);
			if (dx < 0)
				dx = -dx;
			if (dy < 0)
				dy = -dy;
			if (dx < int'(width_q) && dy < int'(height_q))
				return 1'b0;
		end
		r.point_x = it.col;
		r.point_y = it.row;
		if (tbl_n < CAPACITY) begin
			tbl_x[tbl_n] = it.col;
			tbl_y[tbl_n] = it.row;
			tbl_n++;
		end else begin
			r.table_overflow = 1'b1;
		end
		return 1'b1;
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (due_points.size() == 0) begin
				flag_error($sformatf("unexpected point (%0d,%0d)",
					result.point_x, result.point_y));
			end else begin
				want = due_points.pop_front();
				if (result.point_x !== want.point_x)
					flag_error($sformatf("point_x got %0d want %0d",
						result.point_x, want.point_x));
				if (result.point_y !== want.point_y)
					flag_error($sformatf("point_y got %0d want %0d",
						result.point_y, want.point_y));
				if (result.table_overflow !== want.table_overflow)
					flag_error($sformatf("table_overflow got %0b want %0b",
						result.table_overflow, want.table_overflow));
			end
		end
	end

	task automatic send_item(input tds_pkg::item_t it, input int idle_pct,
		input outcome_t outcome, input tds_pkg::result_t res);
		tds_pkg::result_t r;
		bit               hit;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		hit = suppress_step(it, r);
		case (outcome)
			OUT_MODEL: begin
				if (hit)
					due_points.insert(due_points.size(), r);
			end
			OUT_POINT: begin
				due_points.insert(due_points.size(), res);
			end
			default: begin
			end
		endcase
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (busy || due_points.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input tds_pkg::reg_index_t idx, input logic [DW-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			tds_pkg::REG_THRESHOLD: thr_q    = d;
			tds_pkg::REG_TMPL_W:    width_q  = d[CW-1:0];
			tds_pkg::REG_TMPL_H:    height_q = d[CW-1:0];
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	function automatic step_row_t row_item(input int sc, input int c, input int r, input bit fs,
		input outcome_t o, input int px, input int py);
		step_row_t row;
		row.is_cfg             = 1'b0;
		row.idx                = tds_pkg::REG_NONE;
		row.data               = '0;
		row.it.score           = sc[SW-1:0];
		row.it.col             = c[CW-1:0];
		row.it.row             = r[CW-1:0];
		row.it.frame_start     = fs;
		row.outcome            = o;
		row.res.point_x        = px[CW-1:0];
		row.res.point_y        = py[CW-1:0];
		row.res.table_overflow = 1'b0;
		return row;
	endfunction

	function automatic step_row_t row_cfg(input tds_pkg::reg_index_t idx, input int d);
		step_row_t row;
		row        = row_item(0, 0, 0, 1'b0, OUT_NONE, 0, 0);
		row.is_cfg = 1'b1;
		row.idx    = idx;
		row.data   = d[DW-1:0];
		return row;
	endfunction

	task automatic run_frames(input int n_items, input int idle_pct);
		tds_pkg::item_t it;
		int             done;
		int             flen;
		int             w;
		int             x0;
		int             y0;
		int             i;
		int             hit_pct;
		int             t;
		int             s;
		bit             fresh;
		done = 0;
		while (done < n_items) begin
			if ($urandom_range(99) < 15) begin
				it.score       = SW'($urandom);
				it.col         = CW'($urandom);
				it.row         = CW'($urandom);
				it.frame_start = ($urandom_range(7) == 0);
				send_item(it, idle_pct, OUT_MODEL, '0);
				done++;
			end else begin
				flen    = $urandom_range(8, 120);
				if (flen > n_items - done)
					flen = n_items - done;
				w       = $urandom_range(1, 24);
				x0      = $urandom_range(0, 4095 - w);
				y0      = $urandom_range(0, 4095 - 121);
				hit_pct = $urandom_range(5, 60);
				fresh   = ($urandom_range(9) != 0);
				for (i = 0; i < flen; i++) begin
					t = int'(thr_q);
					if ($urandom_range(19) == 0)
						s = t - int'($urandom_range(1));
					else if ($urandom_range(99) < hit_pct)
						s = int'($urandom_range(65535, t + 32768)) - 32768;
					else if (t > -32768)
						s = int'($urandom_range(t + 32767, 0)) - 32768;
					else
						s = int'($urandom_range(65535, 0)) - 32768;
					it.score       = s[SW-1:0];
					it.col         = CW'(x0 + i % w);
					it.row         = CW'(y0 + i / w);
					it.frame_start = fresh && (i == 0);
					send_item(it, idle_pct, OUT_MODEL, '0);
					done++;
				end
			end
		end
	endtask

	initial begin
		step_row_t     rows [$];
		logic [DW-1:0] p_thr;
		int            p_w;
		int            p_h;
		int            p_idle;
		int            p;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.insert(rows.size(), row_item(19661, 0, 0, 1'b1, OUT_POINT, 0, 0));
		rows.insert(rows.size(), row_item(19660, 100, 100, 1'b0, OUT_NONE, 0, 0));
		rows.insert(rows.size(), row_item(32767, 31, 31, 1'b0, OUT_NONE, 0, 0));
		rows.insert(rows.size(), row_item(32767, 32, 0, 1'b0, OUT_POINT, 32, 0));
		rows.insert(rows.size(), row_item(-32768, 4095, 4095, 1'b0, OUT_NONE, 0, 0));
		rows.insert(rows.size(), row_item(32767, 4095, 4095, 1'b0, OUT_POINT, 4095, 4095));
		rows.insert(rows.size(), row_item(32767, 0, 31, 1'b1, OUT_POINT, 0, 31));
		rows.insert(rows.size(), row_cfg(tds_pkg::REG_THRESHOLD, 16'h8000));
		rows.insert(rows.size(), row_item(-32768, 0, 0, 1'b0, OUT_NONE, 0, 0));
		rows.insert(rows.size(), row_cfg(tds_pkg::REG_TMPL_W, 0));
		rows.insert(rows.size(), row_item(-32768, 0, 31, 1'b0, OUT_POINT, 0, 31));
		rows.insert(rows.size(), row_cfg(tds_pkg::REG_TMPL_W, 4095));
		rows.insert(rows.size(), row_cfg(tds_pkg::REG_TMPL_H, 4095));
		rows.insert(rows.size(), row_item(0, 4095, 0, 1'b0, OUT_POINT, 4095, 0));
		rows.insert(rows.size(), row_item(100, 4094, 4095, 1'b0, OUT_NONE, 0, 0));
		rows.insert(rows.size(), row_cfg(tds_pkg::REG_TMPL_H, 0));
		rows.insert(rows.size(), row_item(5, 5, 5, 1'b0, OUT_POINT, 5, 5));
		rows.insert(rows.size(), row_cfg(tds_pkg::REG_NONE, 16'hffff));
		rows.insert(rows.size(), row_cfg(tds_pkg::REG_THRESHOLD, 16'h7fff));
		rows.insert(rows.size(), row_cfg(tds_pkg::REG_TMPL_W, 1));
		rows.insert(rows.size(), row_cfg(tds_pkg::REG_TMPL_H, 1));
		rows.insert(rows.size(), row_item(32766, 7, 9, 1'b1, OUT_NONE, 0, 0));
		rows.insert(rows.size(), row_item(32767, 7, 9, 1'b0, OUT_POINT, 7, 9));
		rows.insert(rows.size(), row_item(32767, 7, 9, 1'b0, OUT_NONE, 0, 0));
		rows.insert(rows.size(), row_item(32767, 8, 9, 1'b0, OUT_MODEL, 0, 0));

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				wait_idle();
				cfg_write(rows[i].idx, rows[i].data);
			end else begin
				send_item(rows[i].it, 0, rows[i].outcome, rows[i].res);
			end
		end

		for (p = 0; p < 6; p++) begin
			case (p)
				0: begin
					p_thr = tds_pkg::THRESHOLD_RST; p_w = 3; p_h = 2; p_idle = 0;
				end
				1: begin
					p_thr = 16'h8000; p_w = 1; p_h = 1; p_idle = 68;
				end
				2: begin
					p_thr = 16'h0000; p_w = 4095; p_h = 4095; p_idle = 0;
				end
				3: begin
					p_thr = DW'($urandom);
					p_w = int'($urandom_range(1, 8));
					p_h = int'($urandom_range(1, 8));
					p_idle = 9;
				end
				4: begin
					p_thr = 16'h7fff; p_w = 0; p_h = 5; p_idle = 68;
				end
				default: begin
					p_thr = DW'($urandom);
					p_w = int'($urandom_range(0, 4095));
					p_h = int'($urandom_range(0, 4095));
					p_idle = 9;
				end
			endcase
			wait_idle();
			cfg_write(tds_pkg::REG_THRESHOLD, p_thr);
			cfg_write(tds_pkg::REG_TMPL_W, p_w[DW-1:0]);
			cfg_write(tds_pkg::REG_TMPL_H, p_h[DW-1:0]);
			run_frames(225, p_idle);
		end

		wait_idle();
		if (err_count == 0) begin
			$display("threshold_detection_suppressor_top_tb: clean");
		end else begin
			$display("threshold_detection_suppressor_top_tb: errors");
		end
		$finish;
	end

endmodule

/* sim.f */
design/tds_pkg.sv
design/tds_scan.sv
design/threshold_detection_suppressor_top.sv
design/tds_checker.sv
sim/threshold_detection_suppressor_top_tb.sv
